// ===== sv/assert_macros.svh =====
// Assertion helpers shared by the reorder buffer RTL.
// Each macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent property, disabled while in reset.
`define SRB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define SRB_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== sv/srb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_pkg
// Shared widths and the slot memory control bundle.
// ----------------------------------------------------------------------------
package srb_pkg;

  localparam int unsigned SeqW        = 4;
  localparam int unsigned OutPayloadW = 32;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } srb_mem_ctrl_t;

endpackage

// ===== sv/srb_slot_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srb_slot_mem
// Slot payload store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module srb_slot_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  logic                  clk_i,
  input  srb_pkg::srb_mem_ctrl_t ctrl_i,
  input  logic [AW-1:0]         waddr_i,
  input  logic [WIDTH-1:0]      wdata_i,
  input  logic [AW-1:0]         raddr_i,
  output logic [WIDTH-1:0]      rdata_o
);
  import srb_pkg::*;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/sequence_reorder_buffer.sv =====
`timescale 1ns / 1ps
// Release: an accept enters StRelease, which sends any ready run to registered outputs.
// Flow: no input is accepted during StRelease; the slot memory has one read port, so
//   one release per cycle after the store cycle while the output is not stalled.
// Reset: state, expected number, slot valid bits and output valid clear asynchronously.
//   The slot memory is not cleared; no clearing pass, inputs are taken right after reset.
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Stores numbered transactions by slot and releases consecutive runs in order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sequence_reorder_buffer #(
  parameter int unsigned DEPTH         = 16,
  parameter int unsigned PAYLOAD_WIDTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [srb_pkg::SeqW-1:0]        seq_number_i,
  input  logic [srb_pkg::OutPayloadW-1:0] payload_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [srb_pkg::SeqW-1:0]        out_seq_number_o,
  output logic [srb_pkg::OutPayloadW-1:0] out_payload_o,
  output logic                            run_last_o
);
  import srb_pkg::*;

  localparam int unsigned IdxW    = $clog2(DEPTH);
  localparam int unsigned SeqExtW = (IdxW > SeqW) ? IdxW : SeqW;
  localparam int unsigned NumSeq  = 2 ** SeqW;

  typedef enum logic {
    StAccept,
    StRelease
  } state_e;

  state_e              state_q;
  logic [IdxW-1:0]     exp_q;
  logic [DEPTH-1:0]    slot_valid_q;
  logic                out_valid_q;
  logic [SeqW-1:0]     out_seq_q;
  logic                out_last_q;

  logic [IdxW-1:0]     idx_lut [NumSeq];
  logic [IdxW-1:0]     wr_idx;
  logic [IdxW-1:0]     exp_nxt;
  logic [SeqExtW-1:0]  exp_ext;
  logic                in_fire;
  logic                can_issue;
  logic                head_valid;
  logic                next_valid;
  logic                issue;
  srb_mem_ctrl_t       mem_ctrl;
  logic [PAYLOAD_WIDTH-1:0] mem_wdata;
  logic [PAYLOAD_WIDTH-1:0] mem_rdata;

  // sequence number modulo DEPTH
  for (genvar s = 0; s < NumSeq; s++) begin : g_idx
    assign idx_lut[s] = IdxW'(s % DEPTH);
  end

  assign wr_idx     = idx_lut[seq_number_i];
  assign exp_nxt    = (exp_q == IdxW'(DEPTH - 1)) ? '0 : IdxW'(exp_q + 1'b1);
  assign exp_ext    = SeqExtW'(exp_q);
  assign in_ready_o = (state_q == StAccept);
  assign in_fire    = in_valid_i && in_ready_o;
  assign can_issue  = !out_valid_q || out_ready_i;
  assign head_valid = slot_valid_q[exp_q];
  assign next_valid = slot_valid_q[exp_nxt];
  assign issue      = (state_q == StRelease) && head_valid && can_issue;

  assign mem_ctrl.wr_en = in_fire;
  assign mem_ctrl.rd_en = issue;
  assign mem_wdata      = PAYLOAD_WIDTH'(payload_i);

  srb_slot_mem #(
    .DEPTH (DEPTH),
    .WIDTH (PAYLOAD_WIDTH),
    .AW    (IdxW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .ctrl_i  (mem_ctrl),
    .waddr_i (wr_idx),
    .wdata_i (mem_wdata),
    .raddr_i (exp_q),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StAccept;
      exp_q        <= '0;
      slot_valid_q <= '0;
      out_valid_q  <= 1'b0;
      out_seq_q    <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (issue) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StAccept: begin
          if (in_fire) begin
            slot_valid_q[wr_idx] <= 1'b1;
            state_q              <= StRelease;
          end
        end
        StRelease: begin
          if (!head_valid) begin
            state_q <= StAccept;
          end else if (can_issue) begin
            slot_valid_q[exp_q] <= 1'b0;
            exp_q               <= exp_nxt;
            out_seq_q           <= exp_ext[SeqW-1:0];
            out_last_q          <= !next_valid;
            if (!next_valid) begin
              state_q <= StAccept;
            end
          end
        end
        default: begin
          state_q <= StAccept;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_seq_number_o = out_seq_q;
  assign out_payload_o    = OutPayloadW'(mem_rdata);
  assign run_last_o       = out_last_q;

  `SRB_ASSERT_NEXT(a_release_clears, issue, !slot_valid_q[$past(exp_q)], "slot not cleared")
  `SRB_ASSERT_NEXT(a_exp_hold, !issue, exp_q == $past(exp_q), "expected number moved without release")
  `SRB_ASSERT(a_run_chain, (out_valid_q && !out_last_q) |-> slot_valid_q[exp_q], "broken run")

endmodule
